>>> src/fvn2d_pkg.sv
package fvn2d_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_WIDTH  = 16;
   localparam int WEIGHT_WIDTH = 17;
   localparam int NOISE_WIDTH = 17;
   // sum of all weighted octaves stays below 2^49
   localparam int ACC_WIDTH   = 49;
   localparam int CELL_STAGES = 9;

   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_XZ  = 32'(64'd374761393 + 64'd668265263);
   localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
   localparam logic [15:0] HASH_MIX_LO  = HASH_MUL_MIX[15:0];
   localparam int          HASH_XSHIFT  = 13;

   localparam logic [17:0] SMOOTH_THREE = 18'd196608;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = 17'h10000;

   typedef struct packed {
      logic                   valid;
      logic [COORD_WIDTH-1:0] cx;
      logic [COORD_WIDTH-1:0] cz;
      logic [ACC_WIDTH-1:0]   acc;
   } fvn2d_link_type;

endpackage

>>> src/fvn2d_cell.sv
module fvn2d_cell #(
   parameter int OCTAVE_INDEX     = 0,
   parameter int BASE_SCALE_SHIFT = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            seed,
   input  fvn2d_pkg::fvn2d_link_type link_in,
   output fvn2d_pkg::fvn2d_link_type link_out
);
   import fvn2d_pkg::*;

   localparam int SHIFT_RAW = BASE_SCALE_SHIFT - OCTAVE_INDEX;
   localparam int SHIFT     = (SHIFT_RAW > FRAC_WIDTH) ? FRAC_WIDTH : SHIFT_RAW;
   localparam int UP        = (SHIFT <= 0) ? -SHIFT : 0;

   logic [31:0] ix, iz;
   logic [FRAC_WIDTH-1:0] fx, fz;

   // lattice index with floor semantics and Q0.16 fraction
   generate
      if (SHIFT <= 0) begin : g_fine
         if (UP >= COORD_WIDTH) begin : g_zero
            assign ix = '0;
            assign iz = '0;
         end else begin : g_left
            assign ix = link_in.cx << UP;
            assign iz = link_in.cz << UP;
         end
         assign fx = '0;
         assign fz = '0;
      end else begin : g_coarse
         localparam logic [31:0] LO_MASK = (32'd1 << SHIFT) - 32'd1;
         assign ix = 32'($signed(link_in.cx) >>> SHIFT);
         assign iz = 32'($signed(link_in.cz) >>> SHIFT);
         assign fx = 16'((link_in.cx & LO_MASK) << (FRAC_WIDTH - SHIFT));
         assign fz = 16'((link_in.cz & LO_MASK) << (FRAC_WIDTH - SHIFT));
      end
   endgenerate

   fvn2d_link_type pipe_ff [CELL_STAGES-1];
   fvn2d_link_type out_ff;

   // stage 1
   logic [31:0] px1_ff, pz1_ff, ffx1_ff, ffz1_ff;
   logic [FRAC_WIDTH-1:0] fx1_ff, fz1_ff;
   // stage 2
   logic [31:0] base2_ff;
   logic [48:0] prx2_ff, prz2_ff;
   // stage 3
   logic [3:0][31:0] h3_ff;
   logic [WEIGHT_WIDTH-1:0] ux3_ff, uz3_ff;
   // stage 4
   logic [3:0][15:0] corner4_ff, corner4_in;
   logic [WEIGHT_WIDTH-1:0] ux4_ff, uz4_ff, vx4_ff, vz4_ff;
   // stage 5
   logic [3:0][31:0] m5_ff;
   logic [WEIGHT_WIDTH-1:0] uz5_ff, vz5_ff;
   // stage 6
   logic [31:0] r0_6_ff, r1_6_ff;
   logic [WEIGHT_WIDTH-1:0] uz6_ff, vz6_ff;
   // stage 7
   logic [47:0] q0_7_ff, q1_7_ff;
   // stage 8
   logic [47:0] ov8_ff;

   logic [17:0] tx, tz;
   assign tx = SMOOTH_THREE - {1'b0, fx1_ff, 1'b0};
   assign tz = SMOOTH_THREE - {1'b0, fz1_ff, 1'b0};

   // xorshift then multiply, only the low half of the hash is kept
   always_comb begin
      logic [31:0] g;
      for (int k = 0; k < 4; k++) begin
         g = h3_ff[k] ^ (h3_ff[k] >> HASH_XSHIFT);
         corner4_in[k] = g[15:0] * HASH_MIX_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CELL_STAGES-1; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else begin
         pipe_ff[0] <= link_in;
         for (int k = 1; k < CELL_STAGES-1; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
         out_ff.valid <= pipe_ff[CELL_STAGES-2].valid;
         out_ff.cx    <= pipe_ff[CELL_STAGES-2].cx;
         out_ff.cz    <= pipe_ff[CELL_STAGES-2].cz;
         out_ff.acc   <= pipe_ff[CELL_STAGES-2].acc + ACC_WIDTH'(ov8_ff >> OCTAVE_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      px1_ff  <= ix * HASH_MUL_X;
      pz1_ff  <= iz * HASH_MUL_Z;
      ffx1_ff <= 32'(fx) * 32'(fx);
      ffz1_ff <= 32'(fz) * 32'(fz);
      fx1_ff  <= fx;
      fz1_ff  <= fz;

      base2_ff <= px1_ff + pz1_ff + seed;
      prx2_ff  <= 49'(ffx1_ff) * 49'(tx);
      prz2_ff  <= 49'(ffz1_ff) * 49'(tz);

      h3_ff[0] <= base2_ff;
      h3_ff[1] <= base2_ff + HASH_MUL_X;
      h3_ff[2] <= base2_ff + HASH_MUL_Z;
      h3_ff[3] <= base2_ff + HASH_MUL_XZ;
      ux3_ff   <= prx2_ff[48:32];
      uz3_ff   <= prz2_ff[48:32];

      corner4_ff <= corner4_in;
      ux4_ff     <= ux3_ff;
      uz4_ff     <= uz3_ff;
      vx4_ff     <= WEIGHT_ONE - ux3_ff;
      vz4_ff     <= WEIGHT_ONE - uz3_ff;

      m5_ff[0] <= 32'(corner4_ff[0]) * 32'(vx4_ff);
      m5_ff[1] <= 32'(corner4_ff[1]) * 32'(ux4_ff);
      m5_ff[2] <= 32'(corner4_ff[2]) * 32'(vx4_ff);
      m5_ff[3] <= 32'(corner4_ff[3]) * 32'(ux4_ff);
      uz5_ff   <= uz4_ff;
      vz5_ff   <= vz4_ff;

      // weights along x sum to one, so each row fits 32 bits
      r0_6_ff <= m5_ff[0] + m5_ff[1];
      r1_6_ff <= m5_ff[2] + m5_ff[3];
      uz6_ff  <= uz5_ff;
      vz6_ff  <= vz5_ff;

      q0_7_ff <= 48'(r0_6_ff) * 48'(vz6_ff);
      q1_7_ff <= 48'(r1_6_ff) * 48'(uz6_ff);

      ov8_ff <= q0_7_ff + q1_7_ff;
   end

   assign link_out = out_ff;

endmodule

>>> src/fractal_value_noise_2d_core.sv
// OCTAVE_COUNT-octave 2-D value noise (four by default). One request is taken in
// every cycle: busy is always low and the result for each request leaves on
// rsp_valid/rsp_noise_sum in request order, for one cycle only.
// Each octave is one cell of a chain with a nine-stage pipeline (split, hash
// multiplies, smoothstep, corner mix, bilinear blend, accumulate); the
// latency is set by that chain. The seed is written through csr_valid/csr_ready
// and should only change while no request is in flight.
module fractal_value_noise_2d_core #(
   parameter int OCTAVE_COUNT     = 4,
   parameter int BASE_SCALE_SHIFT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_z,
   output logic        rsp_valid,
   output logic [fvn2d_pkg::NOISE_WIDTH-1:0] rsp_noise_sum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_noise_seed
);
   import fvn2d_pkg::*;

   logic [31:0] seed_ff;
   fvn2d_link_type link [OCTAVE_COUNT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         seed_ff <= csr_noise_seed;
      end
   end

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      link[0].valid = start && !busy;
      link[0].cx    = req_coord_x;
      link[0].cz    = req_coord_z;
      link[0].acc   = '0;
   end

   generate
      for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_octave
         fvn2d_cell #(
            .OCTAVE_INDEX     (k),
            .BASE_SCALE_SHIFT (BASE_SCALE_SHIFT)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .seed     (seed_ff),
            .link_in  (link[k]),
            .link_out (link[k+1])
         );
      end
   endgenerate

   // accumulator is Q1.48, the result keeps the top 17 bits
   assign rsp_valid     = link[OCTAVE_COUNT].valid;
   assign rsp_noise_sum = link[OCTAVE_COUNT].acc[ACC_WIDTH-1 -: NOISE_WIDTH];

endmodule
